>>> src/bed_pkg.sv
// Shared types, constants and helper functions of the backslash escape decoder.
package bed_pkg;

  // Character codes that the decoder recognizes.
  localparam logic [7:0] ESC_CHAR = 8'h5C;
  localparam logic [7:0] HEX_MARK = 8'h78;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  // Configuration register indexes.
  localparam logic [0:0] CFG_HEX_MODE    = 1'b0;
  localparam logic [0:0] CFG_INPUT_LIMIT = 1'b1;

  // Number of bytes one input request can release, and the queue between front and back.
  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // One input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        out_last;
    logic [15:0] out_count;
  } out_item_t;

  // All result bytes that one input request releases, in order.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [2:0]                  n;
    logic                        last;
  } bundle_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic is_hex_digit(input logic [7:0] c);
    is_hex_digit = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                   (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_value = c[3:0];
    end else begin
      t = (c | 8'h20) - 8'h61 + 8'd10;
      hex_value = t[3:0];
    end
  endfunction

endpackage

>>> src/bed_front.sv
// Front end: configuration registers, escape tracking and grouping of released bytes.
module bed_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  bed_pkg::in_item_t in_data,
  input  bed_pkg::q_status_t q_status,
  output logic              push,
  output bed_pkg::bundle_t  push_data
);
  import bed_pkg::*;

  localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic                   hex_mode_r;
  logic [15:0]            limit_r;
  logic [7:0]             pend_r [3];
  logic [7:0]             pend_nxt [3];
  logic [1:0]             pcnt_r, pcnt_nxt;
  logic [COUNT_WIDTH-1:0] consumed_r, consumed_nxt;
  logic                   stopped_r, stopped_nxt;

  logic                   in_fire;
  logic                   active;
  logic                   room;
  logic                   fits;
  logic [7:0]             esc_val;
  logic [7:0]             b;
  logic [1:0]             flush_n;
  logic                   has_x;
  logic [7:0]             xb;
  bundle_t                bnd;

  assign in_stall = q_status.full;
  assign in_fire  = in_valid && !in_stall;
  assign b        = in_data.in_byte;

  // Position checks against the limit: bytes in range, and room for a full escape.
  assign active = !stopped_r && (CMPW'(consumed_r) < CMPW'(limit_r));
  assign room   = ((CMPW+1)'(consumed_r) + (CMPW+1)'(3)) < (CMPW+1)'(limit_r);

  // Does this byte continue the escape held so far.
  always_comb begin
    if (hex_mode_r) begin
      fits = (pcnt_r == 2'd1) ? (b == HEX_MARK) : is_hex_digit(b);
    end else begin
      fits = (b[7:3] == 5'b00110);
    end
  end

  // Value of a completed escape; the top octal digit keeps only its low two bits.
  always_comb begin
    if (hex_mode_r) begin
      esc_val = {hex_value(pend_r[2]), hex_value(b)};
    end else begin
      esc_val = {pend_r[1][1:0], pend_r[2][2:0], b[2:0]};
    end
  end

  // Escape state update for one accepted byte.
  always_comb begin
    pend_nxt    = pend_r;
    pcnt_nxt    = pcnt_r;
    stopped_nxt = stopped_r;
    flush_n     = 2'd0;
    has_x       = 1'b0;
    xb          = b;
    if (active) begin
      if (pcnt_r != 2'd0 && fits) begin
        if (pcnt_r == 2'd3) begin
          has_x    = 1'b1;
          xb       = esc_val;
          pcnt_nxt = 2'd0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (2'(i) == pcnt_r) begin
              pend_nxt[i] = b;
            end
          end
          pcnt_nxt = pcnt_r + 2'd1;
        end
      end else begin
        // A broken escape releases its held bytes before this byte is judged.
        flush_n  = pcnt_r;
        pcnt_nxt = 2'd0;
        if (b == NUL_CHAR) begin
          stopped_nxt = 1'b1;
        end else if (b == ESC_CHAR && room) begin
          pend_nxt[0] = b;
          pcnt_nxt    = 2'd1;
        end else begin
          has_x = 1'b1;
        end
      end
    end
  end

  // Collect released bytes: flushed escape bytes, byte or escape value, end-of-string flush.
  always_comb begin
    bnd      = '0;
    bnd.last = in_data.in_last;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < flush_n) begin
        bnd.bytes[bnd.n[1:0]] = pend_r[i];
        bnd.n = bnd.n + 3'd1;
      end
    end
    if (has_x) begin
      bnd.bytes[bnd.n[1:0]] = xb;
      bnd.n = bnd.n + 3'd1;
    end
    if (in_data.in_last) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pcnt_nxt) begin
          bnd.bytes[bnd.n[1:0]] = pend_nxt[i];
          bnd.n = bnd.n + 3'd1;
        end
      end
    end
  end

  assign push      = in_fire && (bnd.n != 3'd0 || in_data.in_last);
  assign push_data = bnd;

  // Saturating input position.
  always_comb begin
    consumed_nxt = (consumed_r == '1) ? consumed_r : consumed_r + 1'b1;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_mode_r <= 1'b0;
      limit_r    <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HEX_MODE:    hex_mode_r <= cfg_data[0];
        CFG_INPUT_LIMIT: limit_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-string control state; the end of a string returns it to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r     <= 2'd0;
      consumed_r <= '0;
      stopped_r  <= 1'b0;
    end else if (in_fire) begin
      if (in_data.in_last) begin
        pcnt_r     <= 2'd0;
        consumed_r <= '0;
        stopped_r  <= 1'b0;
      end else begin
        pcnt_r     <= pcnt_nxt;
        consumed_r <= consumed_nxt;
        stopped_r  <= stopped_nxt;
      end
    end
  end

  // Held escape bytes; an entry is read only after it was written in the same escape.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

>>> src/bed_queue.sv
// Small queue of released byte groups between the front and the back end.
module bed_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bed_pkg::bundle_t   push_data,
  input  logic               pop,
  output bed_pkg::bundle_t   head,
  output bed_pkg::q_status_t status
);
  import bed_pkg::*;

  bundle_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign head          = mem_r[rd_ptr_r];
  assign status.empty  = (cnt_r == '0);
  assign status.full   = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));

  // Fill count follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/bed_back.sv
// Back end: splits byte groups into single results, counts output bytes, drives the output register.
module bed_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bed_pkg::bundle_t   head,
  input  bed_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output bed_pkg::out_item_t out_data
);
  import bed_pkg::*;

  logic [1:0]             idx_r, idx_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_inc, cnt_nxt;
  logic                   out_v_r;
  out_item_t              out_r;
  out_item_t              res;
  logic [2:0]             num;
  logic                   final_res;
  logic                   load;

  // Results in the head group: a group with no bytes is a bare end marker.
  assign num       = (head.n == 3'd0) ? 3'd1 : head.n;
  assign final_res = ({1'b0, idx_r} + 3'd1) == num;
  assign load      = !q_status.empty && (!out_v_r || !out_stall);
  assign pop       = load && final_res;

  // Output byte count, saturating.
  always_comb begin
    cnt_inc = cnt_r;
    if (head.n != 3'd0 && cnt_r != '1) begin
      cnt_inc = cnt_r + 1'b1;
    end
  end

  always_comb begin
    res.out_byte  = (head.n == 3'd0) ? 8'h00 : head.bytes[idx_r];
    res.out_valid = (head.n != 3'd0);
    res.out_last  = head.last && final_res;
    res.out_count = 16'(cnt_inc);
  end

  always_comb begin
    idx_nxt = final_res ? 2'd0 : idx_r + 2'd1;
    cnt_nxt = res.out_last ? '0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r   <= idx_nxt;
        cnt_r   <= cnt_nxt;
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> src/backslash_escape_decoder.sv
// Top level of the streaming backslash escape decoder.
//
// Decodes backslash-octal (hex_mode 0) or backslash-x hex (hex_mode 1) escapes in a byte
// stream, one string at a time, with in_last closing each string. One input byte is accepted
// per cycle while in_stall is low. Each byte releases zero to four results, which leave one
// per cycle from a registered output while out_stall is low; a byte that breaks an escape,
// or the end of a string, can release several, and these bursts are absorbed by a four-entry
// queue of byte groups between the escape tracker and the output stage, so in_stall rises
// only when that queue is full. A result is registered in the queue, then in the output
// register, and is taken at a clock edge with out_stall low. The final result of a string has
// out_last set and carries the string's decoded byte count; a last input byte that releases
// no bytes gives a bare marker with out_valid at 0. Configuration is to be written by the user
// through cfg_wr_en, cfg_index and cfg_data while the block is idle, not enforced by the block.
module backslash_escape_decoder #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  bed_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bed_pkg::out_item_t out_data
);
  import bed_pkg::*;

  logic      push;
  bundle_t   push_data;
  logic      pop;
  bundle_t   head;
  q_status_t q_status;

  bed_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  bed_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  bed_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
